// File: design/qept_pkg.sv
`default_nettype none
package qept_pkg;

    // field and register widths
    localparam int Q_W      = 16;
    localparam int GAIN_W   = 16;
    localparam int GAINS_W  = 3 * GAIN_W;
    localparam int DT_W     = 16;
    localparam int ERR_W    = 34;
    localparam int INTEG_W  = 32;
    localparam int TORQUE_W = 32;
    localparam int IN_W     = 11 * Q_W;
    localparam int OUT_W    = 3 * TORQUE_W;

    // shared multiplier and accumulator
    localparam int MA_W   = 17;
    localparam int MB_W   = 41;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 59;

    // sequencer
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(28);

    // APB
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PROP  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DT    = 3'd4;
    localparam logic [DT_W-1:0] DT_RESET = DT_W'(6554);

    // product shift on landing
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_4    = 2'd1;
    localparam logic [1:0] SH_16   = 2'd2;

    // rounding offsets (round half up == floor after adding half)
    localparam logic [ACC_W-1:0] RND_INNER  = ACC_W'(2048);
    localparam logic [ACC_W-1:0] RND_TORQUE = ACC_W'(128);
    localparam logic [19:0]      RND_INTEG  = 20'h80000;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       sub;
        logic [1:0] sh;
    } mac_ctrl_t;

    function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
        sat_hit = (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic logic [31:0] sat_val(input logic signed [ACC_W-1:0] v);
        if (v > SAT_HI) begin
            sat_val = 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            sat_val = 32'h8000_0000;
        end else begin
            sat_val = v[31:0];
        end
    endfunction

    function automatic logic [GAIN_W-1:0] gain_of(input logic [GAINS_W-1:0] p,
                                                  input logic [1:0] ax);
        case (ax)
            2'd0:    gain_of = p[GAIN_W-1:0];
            2'd1:    gain_of = p[2*GAIN_W-1:GAIN_W];
            2'd2:    gain_of = p[3*GAIN_W-1:2*GAIN_W];
            default: gain_of = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: design/quaternion_error_pid_torque_top.sv
// Quaternion-error PID attitude torque controller.
// Input stream (s_*): one word per control step carrying the current and
// reference attitude quaternions (Q1.14) and the three body rates (Q3.12).
// Output stream (m_*): one word per input word with torque x, y, z (Q7.24,
// saturating); m_tuser flags that a torque or an integrator saturated.
// APB port: gains (kp, ki, kd, scale; three Q8.8 each, x lowest) at 0x00,
// 0x08, 0x10, 0x18 and step time (Q0.16) at 0x20. Write only while idle.
// Schedule: all 27 products go through one 17x41 signed multiplier and one
// accumulator under a step counter. An accepted word runs 29 steps, its
// result is loaded into the output register after the last one and the
// next word is taken the cycle after that; words do not overlap.
// The integrators are read before their update within the same control step.
// Stalls: a finished result waits in the output register; the next word is
// taken and worked on meanwhile, and holds on its last step until the
// output register is free.
// Reset (aresetn low, synchronous): integrators cleared, gains zero, step
// time 6554, both streams empty.
`default_nettype none
module quaternion_error_pid_torque_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cur_w, cur_x, cur_y, cur_z, ref_w, ref_x, ref_y, ref_z, rate_x, rate_y, rate_z
    input  wire logic [qept_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // torque_x, torque_y, torque_z
    output logic [qept_pkg::OUT_W-1:0]         m_tdata,
    // clipped
    output logic [0:0]                         m_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [qept_pkg::APB_AW-1:0]   paddr,
    input  wire logic [qept_pkg::APB_DW-1:0]   pwdata,
    output logic [qept_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import qept_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // ---------------- configuration ----------------
    logic [GAINS_W-1:0] prop_gains_reg, integ_gains_reg, deriv_gains_reg, scale_gains_reg;
    logic [DT_W-1:0]    step_time_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gains_reg  <= '0;
            integ_gains_reg <= '0;
            deriv_gains_reg <= '0;
            scale_gains_reg <= '0;
            step_time_reg   <= DT_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PROP:  prop_gains_reg  <= pwdata[GAINS_W-1:0];
                REG_INTEG: integ_gains_reg <= pwdata[GAINS_W-1:0];
                REG_DERIV: deriv_gains_reg <= pwdata[GAINS_W-1:0];
                REG_SCALE: scale_gains_reg <= pwdata[GAINS_W-1:0];
                REG_DT:    step_time_reg   <= pwdata[DT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PROP:  prdata = {{(APB_DW-GAINS_W){1'b0}}, prop_gains_reg};
            REG_INTEG: prdata = {{(APB_DW-GAINS_W){1'b0}}, integ_gains_reg};
            REG_DERIV: prdata = {{(APB_DW-GAINS_W){1'b0}}, deriv_gains_reg};
            REG_SCALE: prdata = {{(APB_DW-GAINS_W){1'b0}}, scale_gains_reg};
            REG_DT:    prdata = {{(APB_DW-DT_W){1'b0}}, step_time_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    logic              state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_tvalid_reg;
    logic              in_acc;
    logic              out_free;
    logic              at_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign at_last  = (state_reg == ST_RUN) && (step_reg == LAST_STEP);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (at_last && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                    end
                end
                ST_RUN: begin
                    if (step_reg == LAST_STEP) begin
                        if (out_free) begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- input word ----------------
    logic signed [Q_W-1:0] cw_reg, cx_reg, cy_reg, cz_reg;
    logic signed [Q_W-1:0] rw_reg, rx_reg, ry_reg, rz_reg;
    logic signed [Q_W-1:0] rate_x_reg, rate_y_reg, rate_z_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cw_reg     <= s_tdata[0*Q_W +: Q_W];
            cx_reg     <= s_tdata[1*Q_W +: Q_W];
            cy_reg     <= s_tdata[2*Q_W +: Q_W];
            cz_reg     <= s_tdata[3*Q_W +: Q_W];
            rw_reg     <= s_tdata[4*Q_W +: Q_W];
            rx_reg     <= s_tdata[5*Q_W +: Q_W];
            ry_reg     <= s_tdata[6*Q_W +: Q_W];
            rz_reg     <= s_tdata[7*Q_W +: Q_W];
            rate_x_reg <= s_tdata[8*Q_W +: Q_W];
            rate_y_reg <= s_tdata[9*Q_W +: Q_W];
            rate_z_reg <= s_tdata[10*Q_W +: Q_W];
        end
    end

    // ---------------- step decode ----------------
    // steps 0-11: error x, y, z (four products each)
    // per axis from base B (12, 17, 22): kp*e, ki*I, kd*rate, dt*e, scale*inner
    logic signed [ERR_W-1:0]   err_reg   [3];
    logic signed [INTEG_W-1:0] integ_reg [3];
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [ACC_W-1:0]          pre_reg, pre_next;
    mac_ctrl_t                 land_reg, issue;
    logic signed [MA_W-1:0]    op_a;
    logic signed [MB_W-1:0]    op_b;
    logic [1:0]                ax;
    logic signed [Q_W-1:0]     rate_sel;

    always_comb begin
        if (step_reg >= STEP_W'(22)) begin
            ax = 2'd2;
        end else if (step_reg >= STEP_W'(17)) begin
            ax = 2'd1;
        end else begin
            ax = 2'd0;
        end
        case (ax)
            2'd0:    rate_sel = rate_x_reg;
            2'd1:    rate_sel = rate_y_reg;
            default: rate_sel = rate_z_reg;
        endcase
    end

    always_comb begin
        issue    = '0;
        op_a     = '0;
        op_b     = '0;
        pre_next = '0;
        if (state_reg == ST_RUN) begin
            case (step_reg)
                // ex = -rw*cx - rz*cy + ry*cz + rx*cw
                5'd0: begin
                    op_a = {rw_reg[Q_W-1], rw_reg};
                    op_b = {{(MB_W-Q_W){cx_reg[Q_W-1]}}, cx_reg};
                    issue = '{vld: 1'b1, first: 1'b1, sub: 1'b1, sh: SH_NONE};
                end
                5'd1: begin
                    op_a = {rz_reg[Q_W-1], rz_reg};
                    op_b = {{(MB_W-Q_W){cy_reg[Q_W-1]}}, cy_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b1, sh: SH_NONE};
                end
                5'd2: begin
                    op_a = {ry_reg[Q_W-1], ry_reg};
                    op_b = {{(MB_W-Q_W){cz_reg[Q_W-1]}}, cz_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b0, sh: SH_NONE};
                end
                5'd3: begin
                    op_a = {rx_reg[Q_W-1], rx_reg};
                    op_b = {{(MB_W-Q_W){cw_reg[Q_W-1]}}, cw_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b0, sh: SH_NONE};
                end
                // ey = rz*cx - rw*cy - rx*cz + ry*cw
                5'd4: begin
                    op_a = {rz_reg[Q_W-1], rz_reg};
                    op_b = {{(MB_W-Q_W){cx_reg[Q_W-1]}}, cx_reg};
                    issue = '{vld: 1'b1, first: 1'b1, sub: 1'b0, sh: SH_NONE};
                end
                5'd5: begin
                    op_a = {rw_reg[Q_W-1], rw_reg};
                    op_b = {{(MB_W-Q_W){cy_reg[Q_W-1]}}, cy_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b1, sh: SH_NONE};
                end
                5'd6: begin
                    op_a = {rx_reg[Q_W-1], rx_reg};
                    op_b = {{(MB_W-Q_W){cz_reg[Q_W-1]}}, cz_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b1, sh: SH_NONE};
                end
                5'd7: begin
                    op_a = {ry_reg[Q_W-1], ry_reg};
                    op_b = {{(MB_W-Q_W){cw_reg[Q_W-1]}}, cw_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b0, sh: SH_NONE};
                end
                // ez = -ry*cx + rx*cy - rw*cz + rz*cw
                5'd8: begin
                    op_a = {ry_reg[Q_W-1], ry_reg};
                    op_b = {{(MB_W-Q_W){cx_reg[Q_W-1]}}, cx_reg};
                    issue = '{vld: 1'b1, first: 1'b1, sub: 1'b1, sh: SH_NONE};
                end
                5'd9: begin
                    op_a = {rx_reg[Q_W-1], rx_reg};
                    op_b = {{(MB_W-Q_W){cy_reg[Q_W-1]}}, cy_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b0, sh: SH_NONE};
                end
                5'd10: begin
                    op_a = {rw_reg[Q_W-1], rw_reg};
                    op_b = {{(MB_W-Q_W){cz_reg[Q_W-1]}}, cz_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b1, sh: SH_NONE};
                end
                5'd11: begin
                    op_a = {rz_reg[Q_W-1], rz_reg};
                    op_b = {{(MB_W-Q_W){cw_reg[Q_W-1]}}, cw_reg};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b0, sh: SH_NONE};
                end
                5'd12, 5'd17, 5'd22: begin
                    op_a = {1'b0, gain_of(prop_gains_reg, ax)};
                    op_b = {{(MB_W-ERR_W){err_reg[ax][ERR_W-1]}}, err_reg[ax]};
                    pre_next = RND_INNER;
                    issue = '{vld: 1'b1, first: 1'b1, sub: 1'b0, sh: SH_NONE};
                end
                5'd13, 5'd18, 5'd23: begin
                    op_a = {1'b0, gain_of(integ_gains_reg, ax)};
                    op_b = {{(MB_W-INTEG_W){integ_reg[ax][INTEG_W-1]}}, integ_reg[ax]};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b0, sh: SH_4};
                end
                5'd14, 5'd19, 5'd24: begin
                    op_a = {1'b0, gain_of(deriv_gains_reg, ax)};
                    op_b = {{(MB_W-Q_W){rate_sel[Q_W-1]}}, rate_sel};
                    issue = '{vld: 1'b1, first: 1'b0, sub: 1'b1, sh: SH_16};
                end
                // integrator update: (I<<20) + half + e*dt, then >>>20
                5'd15, 5'd20, 5'd25: begin
                    op_a = {1'b0, step_time_reg};
                    op_b = {{(MB_W-ERR_W){err_reg[ax][ERR_W-1]}}, err_reg[ax]};
                    pre_next = {{(ACC_W-INTEG_W-20){integ_reg[ax][INTEG_W-1]}},
                                integ_reg[ax], RND_INTEG};
                    issue = '{vld: 1'b1, first: 1'b1, sub: 1'b0, sh: SH_NONE};
                end
                // scale * inner, inner = acc >>> 12
                5'd16, 5'd21, 5'd26: begin
                    op_a = {1'b0, gain_of(scale_gains_reg, ax)};
                    op_b = acc_reg[MB_W+11:12];
                    pre_next = RND_TORQUE;
                    issue = '{vld: 1'b1, first: 1'b1, sub: 1'b0, sh: SH_NONE};
                end
                default: ;
            endcase
        end
    end

    assign prod_next = op_a * op_b;

    // ---------------- multiplier and accumulator ----------------
    logic signed [ACC_W-1:0] prod_ext, prod_sh, acc_base;

    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (land_reg.sh)
            SH_4:    prod_sh = prod_ext <<< 4;
            SH_16:   prod_sh = prod_ext <<< 16;
            default: prod_sh = prod_ext;
        endcase
        acc_base = land_reg.first ? $signed(pre_reg) : acc_reg;
        acc_next = land_reg.sub ? (acc_base - prod_sh) : (acc_base + prod_sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            land_reg <= '0;
        end else begin
            land_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        pre_reg  <= pre_next;
        if (land_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    // ---------------- write-back ----------------
    logic signed [ACC_W-1:0] acc_sh8, acc_sh20;
    logic [TORQUE_W-1:0]     tq_x_reg, tq_y_reg;
    logic                    clip_reg;
    logic [TORQUE_W-1:0]     m_tq_x_reg, m_tq_y_reg, m_tq_z_reg;
    logic                    m_clip_reg;

    assign acc_sh8  = acc_reg >>> 8;
    assign acc_sh20 = acc_reg >>> 20;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            integ_reg[2] <= '0;
        end else if (state_reg == ST_RUN) begin
            case (step_reg)
                5'd17: integ_reg[0] <= sat_val(acc_sh20);
                5'd22: integ_reg[1] <= sat_val(acc_sh20);
                5'd27: integ_reg[2] <= sat_val(acc_sh20);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            clip_reg <= 1'b0;
        end else if (state_reg == ST_RUN) begin
            case (step_reg)
                5'd5:  err_reg[0] <= acc_reg[ERR_W-1:0];
                5'd9:  err_reg[1] <= acc_reg[ERR_W-1:0];
                5'd13: err_reg[2] <= acc_reg[ERR_W-1:0];
                5'd17, 5'd22, 5'd27: clip_reg <= clip_reg | sat_hit(acc_sh20);
                5'd18: begin
                    tq_x_reg <= sat_val(acc_sh8);
                    clip_reg <= clip_reg | sat_hit(acc_sh8);
                end
                5'd23: begin
                    tq_y_reg <= sat_val(acc_sh8);
                    clip_reg <= clip_reg | sat_hit(acc_sh8);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (at_last && out_free) begin
            m_tq_x_reg <= tq_x_reg;
            m_tq_y_reg <= tq_y_reg;
            m_tq_z_reg <= sat_val(acc_sh8);
            m_clip_reg <= clip_reg | sat_hit(acc_sh8);
        end
    end

    assign m_tdata = {m_tq_z_reg, m_tq_y_reg, m_tq_x_reg};
    assign m_tuser = m_clip_reg;

endmodule
`default_nettype wire

// File: design/qept_checker.sv
`default_nettype none
module qept_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [qept_pkg::OUT_W-1:0]  m_tdata,
    input wire logic [0:0]                  m_tuser
);
    // one word in flight: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is being worked on");

    // a result only appears at the end of a word's run
    a_result_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a word in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind quaternion_error_pid_torque_top qept_checker u_qept_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: bench/tb_quaternion_error_pid_torque_top.sv
module tb_quaternion_error_pid_torque_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qept_pkg::*;

    // run length: phases of random words after the directed part
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 142;
    // generous: several times the worst-case run length
    localparam int CYCLE_LIMIT     = 400000;
    // drain for longer than the block takes to work on one word
    localparam int DRAIN_CYCLES    = 60;
    localparam int IDLE_PERCENT    = 31;

    // input word, cur_w in the lowest bits, rate_z in the highest
    typedef struct packed {
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] ref_z;
        logic signed [15:0] ref_y;
        logic signed [15:0] ref_x;
        logic signed [15:0] ref_w;
        logic signed [15:0] cur_z;
        logic signed [15:0] cur_y;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_w;
    } attitude_word_t;

    // result word, torque_x in the lowest bits
    typedef struct packed {
        logic signed [31:0] torque_z;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_x;
    } torque_word_t;

    typedef struct {
        torque_word_t torque;
        logic         clipped;
    } torque_due_t;

    // Keeps its own copy of the gains, step time and integrators, works out
    // the torque word each accepted attitude word should produce, and checks
    // result words against the oldest one still due.
    class torque_ledger;
        logic [GAINS_W-1:0]  kp, ki, kd, ks;
        logic [DT_W-1:0]     dt;
        logic signed [31:0]  integ [3];
        torque_due_t         torques_due [$];
        int unsigned         mismatches;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            ks = '0;
            dt = DT_RESET;
            foreach (integ[a]) integ[a] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] v);
            case (idx)
                REG_PROP:  kp = v[GAINS_W-1:0];
                REG_INTEG: ki = v[GAINS_W-1:0];
                REG_DERIV: kd = v[GAINS_W-1:0];
                REG_SCALE: ks = v[GAINS_W-1:0];
                REG_DT:    dt = v[DT_W-1:0];
                default:   ;    // unmapped index, nothing happens
            endcase
        endfunction

        // round half up of v / 2^s; >>> on a signed longint floors
        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function logic signed [31:0] clamp32(longint v, inout bit hit);
            if (v > longint'(32'sh7FFF_FFFF)) begin
                hit = 1'b1;
                return 32'sh7FFF_FFFF;
            end else if (v < -longint'(32'sh7FFF_FFFF) - 1) begin
                hit = 1'b1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        function longint lane(logic [GAINS_W-1:0] g, int a);
            return longint'(g[16*a +: 16]);
        endfunction

        function void note_attitude(attitude_word_t w);
            longint      cw, cx, cy, cz, rw, rx, ry, rz;
            longint      e [3];
            longint      rate [3];
            longint      inner, inc;
            logic signed [31:0] tq [3];
            bit          hit;
            torque_due_t due;
            hit = 1'b0;
            cw = w.cur_w;  cx = w.cur_x;  cy = w.cur_y;  cz = w.cur_z;
            rw = w.ref_w;  rx = w.ref_x;  ry = w.ref_y;  rz = w.ref_z;
            rate[0] = w.rate_x;
            rate[1] = w.rate_y;
            rate[2] = w.rate_z;
            // vector part of the error quaternion, Q.28, exact
            e[0] = -rw * cx - rz * cy + ry * cz + rx * cw;
            e[1] =  rz * cx - rw * cy - rx * cz + ry * cw;
            e[2] = -ry * cx + rx * cy - rw * cz + rz * cw;
            // torques use the integrators as they stood before this word
            for (int a = 0; a < 3; a++) begin
                inner = round_shift(lane(kp, a) * e[a]
                                    + lane(ki, a) * longint'(integ[a]) * 16
                                    - lane(kd, a) * rate[a] * 65536, 12);
                tq[a] = clamp32(round_shift(lane(ks, a) * inner, 8), hit);
            end
            for (int a = 0; a < 3; a++) begin
                inc      = round_shift(e[a] * longint'(dt), 20);
                integ[a] = clamp32(longint'(integ[a]) + inc, hit);
            end
            due.torque.torque_x = tq[0];
            due.torque.torque_y = tq[1];
            due.torque.torque_z = tq[2];
            due.clipped         = hit;
            torques_due.push_back(due);
        endfunction

        function void flag(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_torque(torque_word_t got, logic clipped);
            torque_due_t due;
            if (torques_due.size() == 0) begin
                flag("unexpected torque word, torque_x", 0, got.torque_x);
                return;
            end
            due = torques_due.pop_front();
            if (got.torque_x !== due.torque.torque_x)
                flag("torque_x", due.torque.torque_x, got.torque_x);
            if (got.torque_y !== due.torque.torque_y)
                flag("torque_y", due.torque.torque_y, got.torque_y);
            if (got.torque_z !== due.torque.torque_z)
                flag("torque_z", due.torque.torque_z, got.torque_z);
            if (clipped !== due.clipped)
                flag("clipped", due.clipped, clipped);
        endfunction

        function int pending();
            return torques_due.size();
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [0:0]          m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // idling switches for each side; cleared for the long quiet stretch
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned cycle_count  = 0;
    torque_ledger ledger;

    quaternion_error_pid_torque_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung block or a lost word ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: back-pressure at random, changed on the falling edge only
    always @(negedge aclk) begin
        m_tready <= !sink_idle_en || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // every torque word taken off the bus is checked at the edge it moves
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_torque(torque_word_t'(m_tdata), m_tuser[0]);
    end

    // Presents one word, with random idle cycles before it, and returns at
    // the falling edge after its handshake. tvalid is left high so that a
    // following word goes out back to back; whoever stops sending lowers it.
    task automatic send_word(input attitude_word_t w);
        while (src_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        ledger.note_attitude(w);
        @(negedge aclk);
    endtask

    // stop sending and wait until every torque word due has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (ledger.pending() != 0);
    endtask

    // APB write: setup, access, then an idle phase so the next one can start
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ledger.write_reg(idx, v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // three Q8.8 lanes: 0 random, 1 zero, 2 all ones, 3 small
    function automatic logic [GAINS_W-1:0] pick_gains(int mode);
        logic [GAINS_W-1:0] g;
        for (int a = 0; a < 3; a++) begin
            case (mode)
                0:       g[16*a +: 16] = 16'($urandom());
                1:       g[16*a +: 16] = '0;
                2:       g[16*a +: 16] = '1;
                default: g[16*a +: 16] = 16'($urandom_range(0, 16'h200));
            endcase
        end
        return g;
    endfunction

    // junk above the register width, which the block must drop
    function automatic logic [APB_DW-1:0] with_junk(logic [GAINS_W-1:0] g);
        return {16'($urandom()), g};
    endfunction

    // Near-full-scale error of one sign: current all at the negative rail,
    // reference w and z at one rail and x and y at the other, with a little
    // noise in the low byte that keeps the signs. Repeated, it drives the
    // integrators to a rail.
    function automatic attitude_word_t strong_word(bit neg);
        attitude_word_t w;
        logic [15:0]    hi, lo;
        hi = neg ? 16'h8000 : 16'h7FFF;
        lo = neg ? 16'h7FFF : 16'h8000;
        w.cur_w  = 16'h8000 ^ 16'($urandom_range(255));
        w.cur_x  = 16'h8000 ^ 16'($urandom_range(255));
        w.cur_y  = 16'h8000 ^ 16'($urandom_range(255));
        w.cur_z  = 16'h8000 ^ 16'($urandom_range(255));
        w.ref_w  = hi ^ 16'($urandom_range(255));
        w.ref_z  = hi ^ 16'($urandom_range(255));
        w.ref_x  = lo ^ 16'($urandom_range(255));
        w.ref_y  = lo ^ 16'($urandom_range(255));
        w.rate_x = 16'($urandom());
        w.rate_y = 16'($urandom());
        w.rate_z = 16'($urandom());
        return w;
    endfunction

    initial begin : stimulus
        attitude_word_t   w;
        logic [IN_W-1:0]  raw;
        logic [DT_W-1:0]  dt_v;
        int               gm [4];
        int unsigned      left, run, pick;
        bit               neg;

        ledger = new();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        // reset settings: zero gains give zero torque; both words carry zero error
        w = '0;
        send_word(w);
        w.cur_w = 16'sd16384;
        w.ref_w = 16'sd16384;
        send_word(w);
        wait_drained();

        // mostly moderate gains, junk above each width; unmapped indexes ignored
        apb_write(REG_PROP,  with_junk({16'h0100, 16'h0200, 16'h0080}));
        apb_write(REG_INTEG, with_junk({16'h0040, 16'h0010, 16'h0100}));
        apb_write(REG_DERIV, with_junk({16'h0180, 16'h0001, 16'hFFFF}));
        apb_write(REG_SCALE, with_junk({16'h0100, 16'h0800, 16'h0020}));
        apb_write(REG_DT,    {48'hFFFF_FFFF_FFFF, 16'h1000});
        for (int i = REG_DT + 1; i < 8; i++)
            apb_write(REG_IDX_W'(i), {$urandom(), $urandom()});

        // field extremes, unnormalised quaternions, zero-error cases
        w = '{default: 16'sh7FFF};
        send_word(w);
        w = '{default: 16'sh8000};
        send_word(w);
        w = '{default: 16'sh8000};
        w.ref_w = 16'sh7FFF;  w.ref_x = 16'sh7FFF;
        w.ref_y = 16'sh7FFF;  w.ref_z = 16'sh7FFF;
        w.rate_x = 16'sh7FFF;
        send_word(w);
        // current equal to reference: error vector is zero
        w = attitude_word_t'(IN_W'({$urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom(), $urandom()}));
        w.ref_w = w.cur_w;  w.ref_x = w.cur_x;
        w.ref_y = w.cur_y;  w.ref_z = w.cur_z;
        send_word(w);
        // reference the negation of current: also zero error
        w.ref_w = -w.cur_w;  w.ref_x = -w.cur_x;
        w.ref_y = -w.cur_y;  w.ref_z = -w.cur_z;
        send_word(w);
        wait_drained();

        // all gains and step time at the top: torque and integrator clipping
        apb_write(REG_PROP,  with_junk('1));
        apb_write(REG_INTEG, with_junk('1));
        apb_write(REG_DERIV, with_junk('1));
        apb_write(REG_SCALE, with_junk('1));
        apb_write(REG_DT,    {48'h0, 16'hFFFF});
        repeat (9) send_word(strong_word(1'b0));
        wait_drained();

        // --- random part, a new setting per phase ---
        for (int p = 0; p < PHASES; p++) begin
            dt_v = 16'($urandom());
            case (p)
                0: gm = '{0, 0, 0, 0};
                1: begin
                    gm   = '{1, 1, 1, 1};
                    dt_v = '0;
                end
                2: begin
                    gm   = '{2, 2, 2, 2};
                    dt_v = '1;
                end
                3: gm = '{3, 3, 3, 3};
                default: begin
                    foreach (gm[r]) gm[r] = $urandom_range(3);
                    if ($urandom_range(3) == 0)
                        dt_v = $urandom_range(1) ? '1 : '0;
                end
            endcase
            apb_write(REG_PROP,  with_junk(pick_gains(gm[0])));
            apb_write(REG_INTEG, with_junk(pick_gains(gm[1])));
            apb_write(REG_DERIV, with_junk(pick_gains(gm[2])));
            apb_write(REG_SCALE, with_junk(pick_gains(gm[3])));
            apb_write(REG_DT,    {{$urandom(), 16'($urandom())}, dt_v});

            // long stretch with neither side idling
            src_idle_en  = (p != 3);
            sink_idle_en = (p != 3);

            left = WORDS_PER_PHASE;
            while (left > 0) begin
                if ($urandom_range(99) < 20) begin
                    // run of same-sign large errors, walks an integrator to a rail
                    neg = 1'($urandom_range(1));
                    run = $urandom_range(6, 20);
                    repeat (run) begin
                        send_word(strong_word(neg));
                        if (left > 0)
                            left--;
                    end
                end else begin
                    pick = $urandom_range(99);
                    for (int f = 0; f < 11; f++) begin
                        if (pick < 60) begin
                            raw[16*f +: 16] = 16'($urandom());
                        end else if (pick < 80) begin
                            // roughly unit-sized quaternion parts and rates
                            raw[16*f +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
                        end else begin
                            case ($urandom_range(4))
                                0:       raw[16*f +: 16] = 16'h8000;
                                1:       raw[16*f +: 16] = 16'h7FFF;
                                2:       raw[16*f +: 16] = 16'h0000;
                                3:       raw[16*f +: 16] = 16'hFFFF;
                                default: raw[16*f +: 16] = 16'($urandom());
                            endcase
                        end
                    end
                    send_word(attitude_word_t'(raw));
                    left--;
                end
            end
            wait_drained();
        end

        // --- end of run: look out for stray words, then report ---
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
design/qept_pkg.sv
design/quaternion_error_pid_torque_top.sv
design/qept_checker.sv
bench/tb_quaternion_error_pid_torque_top.sv
